// ===== hw/rtl/mlfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, constants and helpers for the four-level dispatch scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int unsigned SLOTS     = 64;
  localparam int unsigned LEVELS    = 4;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned QUOTA_W   = 16;
  localparam int unsigned QLEN_W    = 7;
  localparam int unsigned QADDR_W   = LVL_W + SLOT_W;
  localparam int unsigned CADDR_W   = SLOT_W + LVL_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0] TOP_LEVEL = 2'd3;

  localparam logic [QUOTA_W-1:0] QUOTA_TOP_RST  = 16'd8;
  localparam logic [QUOTA_W-1:0] QUOTA_UMID_RST = 16'd16;
  localparam logic [QUOTA_W-1:0] QUOTA_LMID_RST = 16'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA_TOP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA_UMID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA_LMID = 2'd2;

  localparam logic [2:0] MODE_ADMIT    = 3'd0;
  localparam logic [2:0] MODE_EXIT     = 3'd1;
  localparam logic [2:0] MODE_SLEEP    = 3'd2;
  localparam logic [2:0] MODE_WAKE     = 3'd3;
  localparam logic [2:0] MODE_DISPATCH = 3'd4;
  localparam logic [2:0] MODE_QUERY    = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_STATE = 2'd1;
  localparam logic [1:0] STATUS_IDLE  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADMIT, OP_EXIT, OP_SLEEP, OP_WAKE, OP_DISPATCH, OP_QUERY, OP_NOP
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADMIT_CLR, ST_SCAN_RD, ST_SCAN_CHK, ST_SHIFT_RD, ST_SHIFT_WR,
    ST_APPEND, ST_EXIT_END, ST_RUN_RD, ST_RUN_WR, ST_WAIT, ST_QUERY_RD,
    ST_QUERY_OUT, ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [LVL_W-1:0]  query_level;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] chosen_slot;
    logic [LVL_W-1:0]  chosen_level;
    logic              demoted;
    logic [CNT_W-1:0]  run_count;
    logic [CNT_W-1:0]  wait_count;
  } res_t;

  typedef struct packed {
    logic [QUOTA_W-1:0] top;
    logic [QUOTA_W-1:0] upper_mid;
    logic [QUOTA_W-1:0] lower_mid;
  } quota_t;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [LVL_W-1:0]  query_level;
  } op_cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    op_cmd_t cmd;
  } head_t;

  function automatic logic [QUOTA_W-1:0] quota_of(quota_t q, logic [LVL_W-1:0] lv);
    logic [QUOTA_W-1:0] r;
    case (lv)
      2'd3:    r = q.top;
      2'd2:    r = q.upper_mid;
      default: r = q.lower_mid;
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/mlfq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_front
// Takes commands, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mlfq_front import mlfq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  cmd_t  cmd_i,
  input  logic  pop_i,
  output logic  busy_o,
  output head_t head_o
);

  op_cmd_t    fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  op_cmd_t    dec;

  always_comb begin
    dec.slot        = cmd_i.slot;
    dec.query_level = cmd_i.query_level;
    case (cmd_i.mode)
      MODE_ADMIT:    dec.op = OP_ADMIT;
      MODE_EXIT:     dec.op = OP_EXIT;
      MODE_SLEEP:    dec.op = OP_SLEEP;
      MODE_WAKE:     dec.op = OP_WAKE;
      MODE_DISPATCH: dec.op = OP_DISPATCH;
      MODE_QUERY:    dec.op = OP_QUERY;
      default:       dec.op = OP_NOP;
    endcase
  end

  assign busy_o = (count_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.cmd   = fifo_q[rd_ptr_q];

endmodule

// ===== hw/rtl/mlfq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_back
// Sequencer that carries out one command over the queue and counter memories.
// ----------------------------------------------------------------------------
module mlfq_back import mlfq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  quota_t quota_i,
  input  head_t  head_i,
  output logic   pop_o,
  output logic   done_o,
  output res_t   result_o
);

  state_e state_q, state_d;

  op_cmd_t            cmd_q;
  logic [LVL_W-1:0]   lv_q;
  logic [SLOT_W-1:0]  p_q;
  logic [QLEN_W-1:0]  cnt_q;
  logic [QLEN_W-1:0]  i_q;
  logic [SLOT_W-1:0]  pos_q;
  logic [SLOT_W-1:0]  sel_q;
  logic               found_q;
  logic               demote_q;
  res_t               res_q;

  logic [SLOTS-1:0]   in_use_q;
  logic [SLOTS-1:0]   runnable_q;
  logic [LVL_W-1:0]   level_q [SLOTS];
  logic [QLEN_W-1:0]  qlen_q [LEVELS];
  logic [QLEN_W-1:0]  ptr_q;

  logic               wpend_q;
  logic [CADDR_W-1:0] wpaddr_q;

  // memories
  logic [SLOT_W-1:0]  qmem [SLOTS*LEVELS];
  logic [CNT_W-1:0]   run_mem [SLOTS*LEVELS];
  logic [CNT_W-1:0]   wait_mem [SLOTS*LEVELS];
  logic [SLOT_W-1:0]  q_rdata;
  logic [CNT_W-1:0]   run_rdata, wait_rdata;

  logic [QADDR_W-1:0] q_raddr, q_waddr;
  logic               q_we;
  logic [SLOT_W-1:0]  q_wdata;
  logic [CADDR_W-1:0] run_raddr, run_waddr, wait_raddr, wait_waddr;
  logic               run_we, wait_we;
  logic [CNT_W-1:0]   run_wdata, wait_wdata;

  // helpers
  logic [QLEN_W-1:0]  n_cur;
  logic               scan_end, scan_hit, shift_end, is_exit;
  logic [LVL_W-1:0]   app_lv;
  logic [CNT_W-1:0]   run_new;
  logic [SLOT_W-1:0]  wi;
  logic               w_elig, sweep_end;
  logic [QLEN_W-1:0]  p_next_full;
  logic [QLEN_W-1:0]  l0_len;
  logic [SLOT_W-1:0]  l0_start;

  assign n_cur     = qlen_q[lv_q];
  assign is_exit   = (cmd_q.op == OP_EXIT);
  assign scan_end  = (cnt_q == n_cur);
  assign scan_hit  = is_exit ? (q_rdata == cmd_q.slot) : runnable_q[q_rdata];
  assign shift_end = ((i_q + 1'b1) >= n_cur);
  assign app_lv    = (cmd_q.op == OP_ADMIT) ? TOP_LEVEL : lv_q - 1'b1;
  assign run_new   = sat_inc(run_rdata);
  assign wi        = i_q[SLOT_W-1:0];
  assign sweep_end = (i_q == QLEN_W'(SLOTS));
  assign w_elig    = !sweep_end && (wi != sel_q) && in_use_q[wi] && runnable_q[wi];
  assign p_next_full = {1'b0, p_q} + 1'b1;
  assign l0_len    = qlen_q[0];
  assign l0_start  = (ptr_q < l0_len) ? ptr_q[SLOT_W-1:0] : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.cmd.op)
            OP_ADMIT:
              state_d = in_use_q[head_i.cmd.slot] ? ST_DONE : ST_ADMIT_CLR;
            OP_EXIT:
              state_d = in_use_q[head_i.cmd.slot] ? ST_SCAN_RD : ST_DONE;
            OP_DISPATCH: state_d = ST_SCAN_RD;
            OP_QUERY:    state_d = ST_QUERY_RD;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_ADMIT_CLR: if (i_q[1:0] == 2'd3) state_d = ST_APPEND;
      ST_SCAN_RD: begin
        if (!scan_end) begin
          state_d = ST_SCAN_CHK;
        end else if (is_exit) begin
          state_d = ST_EXIT_END;
        end else if (lv_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN_CHK: begin
        if (!scan_hit)    state_d = ST_SCAN_RD;
        else if (is_exit) state_d = ST_SHIFT_RD;
        else              state_d = ST_RUN_RD;
      end
      ST_SHIFT_RD: begin
        if (!shift_end)   state_d = ST_SHIFT_WR;
        else if (is_exit) state_d = ST_EXIT_END;
        else              state_d = ST_APPEND;
      end
      ST_SHIFT_WR:  state_d = ST_SHIFT_RD;
      ST_APPEND:    state_d = ST_DONE;
      ST_EXIT_END:  state_d = ST_DONE;
      ST_RUN_RD:    state_d = ST_RUN_WR;
      ST_RUN_WR:    state_d = ST_WAIT;
      ST_WAIT: begin
        if (sweep_end) state_d = demote_q ? ST_SHIFT_RD : ST_DONE;
      end
      ST_QUERY_RD:  state_d = ST_QUERY_OUT;
      ST_QUERY_OUT: state_d = ST_DONE;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // memory port control and strobes
  always_comb begin
    pop_o      = (state_q == ST_IDLE) && head_i.valid;
    done_o     = (state_q == ST_DONE);
    q_raddr    = {lv_q, p_q};
    q_we       = 1'b0;
    q_waddr    = {lv_q, i_q[SLOT_W-1:0]};
    q_wdata    = q_rdata;
    run_raddr  = {sel_q, lv_q};
    run_we     = 1'b0;
    run_waddr  = {sel_q, lv_q};
    run_wdata  = run_new;
    wait_raddr = {wi, level_q[wi]};
    wait_we    = 1'b0;
    wait_waddr = wpaddr_q;
    wait_wdata = sat_inc(wait_rdata);
    case (state_q)
      ST_ADMIT_CLR: begin
        run_we     = 1'b1;
        run_waddr  = {cmd_q.slot, i_q[1:0]};
        run_wdata  = '0;
        wait_we    = 1'b1;
        wait_waddr = {cmd_q.slot, i_q[1:0]};
        wait_wdata = '0;
      end
      ST_SHIFT_RD: q_raddr = {lv_q, i_q[SLOT_W-1:0] + 1'b1};
      ST_SHIFT_WR: q_we = 1'b1;
      ST_APPEND: begin
        q_we    = (qlen_q[app_lv] < QLEN_W'(SLOTS));
        q_waddr = {app_lv, qlen_q[app_lv][SLOT_W-1:0]};
        q_wdata = (cmd_q.op == OP_ADMIT) ? cmd_q.slot : sel_q;
      end
      ST_RUN_WR: run_we = 1'b1;
      ST_WAIT:   wait_we = wpend_q;
      ST_QUERY_RD: begin
        run_raddr  = {cmd_q.slot, cmd_q.query_level};
        wait_raddr = {cmd_q.slot, cmd_q.query_level};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    q_rdata    <= qmem[q_raddr];
    run_rdata  <= run_mem[run_raddr];
    wait_rdata <= wait_mem[wait_raddr];
    if (q_we)    qmem[q_waddr] <= q_wdata;
    if (run_we)  run_mem[run_waddr] <= run_wdata;
    if (wait_we) wait_mem[wait_waddr] <= wait_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_use_q   <= '0;
      runnable_q <= '0;
      for (int k = 0; k < SLOTS; k++) level_q[k] <= '0;
      for (int k = 0; k < LEVELS; k++) qlen_q[k] <= '0;
      ptr_q      <= '0;
      wpend_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_SCAN_CHK: begin
          if (scan_hit && !is_exit && lv_q == '0) ptr_q <= p_next_full;
        end
        ST_SHIFT_RD: begin
          if (shift_end) qlen_q[lv_q] <= n_cur - 1'b1;
        end
        ST_APPEND: begin
          if (qlen_q[app_lv] < QLEN_W'(SLOTS)) qlen_q[app_lv] <= qlen_q[app_lv] + 1'b1;
          if (cmd_q.op == OP_ADMIT) begin
            in_use_q[cmd_q.slot]   <= 1'b1;
            runnable_q[cmd_q.slot] <= 1'b1;
            level_q[cmd_q.slot]    <= TOP_LEVEL;
          end else begin
            level_q[sel_q] <= app_lv;
          end
        end
        ST_EXIT_END: begin
          if (found_q && lv_q == '0 && {1'b0, pos_q} < ptr_q) ptr_q <= ptr_q - 1'b1;
          in_use_q[cmd_q.slot]   <= 1'b0;
          runnable_q[cmd_q.slot] <= 1'b0;
        end
        ST_IDLE: begin
          if (head_i.valid && in_use_q[head_i.cmd.slot]) begin
            if (head_i.cmd.op == OP_SLEEP) runnable_q[head_i.cmd.slot] <= 1'b0;
            if (head_i.cmd.op == OP_WAKE)  runnable_q[head_i.cmd.slot] <= 1'b1;
          end
          wpend_q <= 1'b0;
        end
        ST_WAIT: begin
          wpend_q  <= w_elig;
          wpaddr_q <= {wi, level_q[wi]};
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q    <= head_i.cmd;
        i_q      <= '0;
        p_q      <= '0;
        cnt_q    <= '0;
        found_q  <= 1'b0;
        demote_q <= 1'b0;
        lv_q     <= (head_i.cmd.op == OP_EXIT) ? level_q[head_i.cmd.slot] : TOP_LEVEL;
        res_q    <= '0;
        res_q.chosen_slot <= (head_i.cmd.op == OP_DISPATCH) ? '0 : head_i.cmd.slot;
        case (head_i.cmd.op)
          OP_ADMIT: begin
            if (in_use_q[head_i.cmd.slot]) res_q.status <= STATUS_STATE;
          end
          OP_EXIT, OP_SLEEP, OP_WAKE: begin
            if (!in_use_q[head_i.cmd.slot]) begin
              res_q.status <= STATUS_STATE;
            end else begin
              res_q.chosen_level <= level_q[head_i.cmd.slot];
            end
          end
          default: ;
        endcase
      end
      ST_ADMIT_CLR: i_q <= i_q + 1'b1;
      ST_SCAN_RD: begin
        if (scan_end && !is_exit) begin
          if (lv_q == '0) begin
            res_q.status <= STATUS_IDLE;
          end else begin
            lv_q  <= lv_q - 1'b1;
            cnt_q <= '0;
            p_q   <= (lv_q == 2'd1) ? l0_start : '0;
          end
        end
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          pos_q   <= p_q;
          i_q     <= {1'b0, p_q};
          sel_q   <= q_rdata;
          found_q <= 1'b1;
          if (!is_exit) begin
            res_q.chosen_slot  <= q_rdata;
            res_q.chosen_level <= lv_q;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
          p_q   <= (p_next_full == n_cur) ? '0 : p_next_full[SLOT_W-1:0];
        end
      end
      ST_SHIFT_WR: i_q <= i_q + 1'b1;
      ST_APPEND: begin
        if (cmd_q.op == OP_ADMIT) res_q.chosen_level <= TOP_LEVEL;
        else                      res_q.demoted <= 1'b1;
      end
      ST_EXIT_END: res_q.chosen_level <= lv_q;
      ST_RUN_WR: begin
        demote_q <= (lv_q != '0) && ({16'd0, quota_of(quota_i, lv_q)} <= run_new);
        i_q      <= '0;
      end
      ST_WAIT: begin
        if (!sweep_end) i_q <= i_q + 1'b1;
        else            i_q <= {1'b0, pos_q};
      end
      ST_QUERY_OUT: begin
        res_q.chosen_level <= level_q[cmd_q.slot];
        res_q.run_count    <= run_rdata;
        res_q.wait_count   <= wait_rdata;
      end
      default: ;
    endcase
  end

  assign result_o = res_q;

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");
  a_qlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q[0] <= QLEN_W'(SLOTS) && qlen_q[1] <= QLEN_W'(SLOTS) &&
    qlen_q[2] <= QLEN_W'(SLOTS) && qlen_q[3] <= QLEN_W'(SLOTS))
    else $error("queue length beyond slot count");
  a_admit_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPEND && cmd_q.op == OP_ADMIT) |=> in_use_q[cmd_q.slot])
    else $error("admitted slot not marked in use");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q != ST_IDLE) else $error("command popped but not started");
`endif

endmodule

// ===== hw/rtl/mlfq_dispatch_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfq_dispatch_scheduler
// Four-level feedback dispatch scheduler with a command queue in front of a
// sequencer over the run queue and tick counter memories.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  command   start_i / busy_o            cmd_i      (cmd_t)
//  result    done_o (one-cycle strobe)   result_o   (res_t)
//  config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Exit scans its level's queue entry by entry and then compacts it. Dispatch
// scans queues entry by entry, then sweeps all 64 slots to update wait
// counts, plus a compaction when it demotes. The command queue holds two
// transactions; busy_o rises when it is full. Results cannot be stalled.
// Reset leaves all queues empty, no memory sweep.
module mlfq_dispatch_scheduler import mlfq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  cmd_t                 cmd_i,
  output logic                 done_o,
  output res_t                 result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [QUOTA_W-1:0]   cfg_data_i
);

  quota_t quota_q;
  head_t  head;
  logic   pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q.top       <= QUOTA_TOP_RST;
      quota_q.upper_mid <= QUOTA_UMID_RST;
      quota_q.lower_mid <= QUOTA_LMID_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_QUOTA_TOP:  quota_q.top       <= cfg_data_i;
        CFG_QUOTA_UMID: quota_q.upper_mid <= cfg_data_i;
        CFG_QUOTA_LMID: quota_q.lower_mid <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mlfq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .pop_i  (pop),
    .busy_o (busy_o),
    .head_o (head)
  );

  mlfq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .quota_i (quota_q),
    .head_i  (head),
    .pop_o   (pop),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule
